### sv/bcq_pkg.sv
// ----------------------------------------------------------------------------
// bcq_pkg
// Types and constants shared by the LRU block cache with owner quota.
// ----------------------------------------------------------------------------
`default_nettype none

package bcq_pkg;

  localparam int unsigned MinQuota = 3;
  localparam int unsigned QuotaW   = 7;
  localparam int unsigned IdxW     = 6;  // widest entry index (64 entries)
  localparam int unsigned CntW     = 7;  // owner count up to 64

  typedef enum logic [0:0] {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } bcq_op_e;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_WAIT     = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOT_BUSY = 3'd4
  } bcq_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REL,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } bcq_state_e;

  typedef struct packed {
    bcq_op_e     operation;
    logic [7:0]  device;
    logic [31:0] sector;
    logic [15:0] inode;
    logic [5:0]  entry_index;
  } bcq_req_t;

  typedef struct packed {
    bcq_status_e status;
    logic [5:0]  granted_entry;
  } bcq_res_t;

  typedef struct packed {
    logic [7:0]  device;
    logic [31:0] sector;
    logic [15:0] owner;
  } bcq_tag_t;

  // running result of one pass over the entries
  typedef struct packed {
    logic            hit_found;
    logic            hit_busy;
    logic [IdxW-1:0] hit_idx;
    logic [CntW-1:0] own_cnt;
    logic            lru_found;
    logic [IdxW-1:0] lru_idx;
    logic [IdxW-1:0] lru_rank;
    logic            own_found;
    logic [IdxW-1:0] own_idx;
    logic [IdxW-1:0] own_rank;
  } bcq_scan_t;

endpackage

`default_nettype wire

### sv/bcq_tag_mem.sv
// ----------------------------------------------------------------------------
// bcq_tag_mem
// Tag store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bcq_tag_mem #(
  parameter int unsigned NUM_ENTRIES = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           we_i,
  input  wire logic [$clog2(NUM_ENTRIES)-1:0] waddr_i,
  input  wire bcq_pkg::bcq_tag_t              wdata_i,
  input  wire logic [$clog2(NUM_ENTRIES)-1:0] raddr_i,
  output bcq_pkg::bcq_tag_t                   rdata_o
);

  bcq_pkg::bcq_tag_t mem_q [NUM_ENTRIES];
  bcq_pkg::bcq_tag_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/bcq_recency.sv
// ----------------------------------------------------------------------------
// bcq_recency
// Recency ranks, one cell per entry; a release moves an entry to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module bcq_recency #(
  parameter int unsigned NUM_ENTRIES = 16
) (
  input  wire logic                                            clk_i,
  input  wire logic                                            rst_ni,
  input  wire logic                                            rel_en_i,
  input  wire logic [$clog2(NUM_ENTRIES)-1:0]                  rel_idx_i,
  output logic [NUM_ENTRIES-1:0][$clog2(NUM_ENTRIES)-1:0]      rank_o
);

  localparam int unsigned IW = $clog2(NUM_ENTRIES);

  logic [NUM_ENTRIES-1:0][IW-1:0] rank_q, rank_d;
  logic [IW-1:0]                  rel_rank;

  assign rel_rank = rank_q[rel_idx_i];

  always_comb begin
    rank_d = rank_q;
    if (rel_en_i) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (IW'(i) == rel_idx_i) begin
          rank_d[i] = IW'(NUM_ENTRIES - 1);
        end else if (rank_q[i] > rel_rank) begin
          rank_d[i] = rank_q[i] - IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        rank_q[i] <= IW'(i);
      end
    end else begin
      rank_q <= rank_d;
    end
  end

  assign rank_o = rank_q;

  a_rel_to_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_en_i |=> rank_q[$past(rel_idx_i)] == IW'(NUM_ENTRIES - 1))
    else $error("released entry not most recent");

endmodule

`default_nettype wire

### sv/bcq_scan.sv
// ----------------------------------------------------------------------------
// bcq_scan
// Folds one entry per cycle, while vld_i is high, into match, owner count and LRU choices.
// ----------------------------------------------------------------------------
`default_nettype none

module bcq_scan (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       clr_i,
  input  wire logic                       vld_i,
  input  wire logic [bcq_pkg::IdxW-1:0]   idx_i,
  input  wire logic [bcq_pkg::IdxW-1:0]   rank_i,
  input  wire logic                       used_i,
  input  wire logic                       busy_i,
  input  wire bcq_pkg::bcq_tag_t          tag_i,
  input  wire logic [7:0]                 device_i,
  input  wire logic [31:0]                sector_i,
  input  wire logic [15:0]                inode_i,
  output bcq_pkg::bcq_scan_t              sum_o
);

  bcq_pkg::bcq_scan_t sum_q, sum_d;
  logic               blk_match;
  logic               own_match;

  assign blk_match = used_i && (tag_i.device == device_i) && (tag_i.sector == sector_i);
  assign own_match = used_i && (tag_i.device == device_i) && (tag_i.owner == inode_i);

  always_comb begin
    sum_d = sum_q;
    if (clr_i) begin
      sum_d = '0;
    end else if (vld_i) begin
      if (blk_match && !sum_q.hit_found) begin
        sum_d.hit_found = 1'b1;
        sum_d.hit_busy  = busy_i;
        sum_d.hit_idx   = idx_i;
      end
      if (own_match) begin
        sum_d.own_cnt = sum_q.own_cnt + bcq_pkg::CntW'(1);
      end
      if (!busy_i && (!sum_q.lru_found || rank_i < sum_q.lru_rank)) begin
        sum_d.lru_found = 1'b1;
        sum_d.lru_idx   = idx_i;
        sum_d.lru_rank  = rank_i;
      end
      if (!busy_i && own_match && (!sum_q.own_found || rank_i < sum_q.own_rank)) begin
        sum_d.own_found = 1'b1;
        sum_d.own_idx   = idx_i;
        sum_d.own_rank  = rank_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

### sv/lru_block_cache_with_owner_quota_core.sv
// ----------------------------------------------------------------------------
// lru_block_cache_with_owner_quota_core
// Fully associative buffer cache with LRU allocation and per-owner quota.
// ----------------------------------------------------------------------------
// Acquire: a pass over all entries in S_SCAN, one tag memory read per cycle, then
//   S_DRAIN and S_DECIDE; the result strobe is registered from S_DECIDE.
// Release: the result strobe is registered from S_REL.
// Busy drops in the strobe cycle; no new request is taken before then.
// done_o is high for a single cycle with the result on res_o; the receiver cannot stall.
// Reset: all entries unused and free, entry i at recency rank i, quota 0.
`default_nettype none

module lru_block_cache_with_owner_quota_core #(
  parameter int unsigned NUM_ENTRIES = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire bcq_pkg::bcq_req_t req_i,
  output logic                   done_o,
  output bcq_pkg::bcq_res_t      res_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [6:0]        cfg_data_i
);

  localparam int unsigned IW = $clog2(NUM_ENTRIES);

  bcq_pkg::bcq_state_e            state_q, state_d;
  bcq_pkg::bcq_req_t              req_q;
  logic [IW-1:0]                  cnt_q, cnt_d;
  logic                           vld_q;
  logic [IW-1:0]                  idx_q;
  logic [NUM_ENTRIES-1:0]         used_q, used_d;
  logic [NUM_ENTRIES-1:0]         busy_q, busy_d;
  logic [bcq_pkg::QuotaW-1:0]     quota_q;
  bcq_pkg::bcq_res_t              res_q, res_d;
  logic                           done_q, done_d;

  logic                           mem_we;
  bcq_pkg::bcq_tag_t              mem_wdata;
  bcq_pkg::bcq_tag_t              mem_rdata;
  logic [NUM_ENTRIES-1:0][IW-1:0] rank;
  logic                           rel_en;
  logic [IW-1:0]                  rel_idx;
  logic                           rel_ok;
  logic                           scan_clr;
  bcq_pkg::bcq_scan_t             sum;
  logic                           limited;
  logic                           vic_found;
  logic [IW-1:0]                  vic_idx;
  logic [IW-1:0]                  hit_idx;

  assign busy        = (state_q != bcq_pkg::S_IDLE);
  assign cfg_ready_o = !busy;
  assign done_o      = done_q;
  assign res_o       = res_q;

  assign rel_idx = req_q.entry_index[IW-1:0];
  assign rel_ok  = ({1'b0, req_q.entry_index} < 7'(NUM_ENTRIES)) && busy_q[rel_idx];

  assign limited = (quota_q >= bcq_pkg::QuotaW'(bcq_pkg::MinQuota))
                && (req_q.inode != '0)
                && (bcq_pkg::QuotaW'(sum.own_cnt) >= quota_q);
  assign vic_found = limited ? sum.own_found : sum.lru_found;
  assign vic_idx   = limited ? sum.own_idx[IW-1:0] : sum.lru_idx[IW-1:0];
  assign hit_idx   = sum.hit_idx[IW-1:0];

  assign mem_wdata.device = req_q.device;
  assign mem_wdata.sector = req_q.sector;
  assign mem_wdata.owner  = req_q.inode;

  bcq_tag_mem #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_tag_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(vic_idx),
    .wdata_i(mem_wdata),
    .raddr_i(cnt_q),
    .rdata_o(mem_rdata)
  );

  bcq_recency #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_recency (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rel_en_i (rel_en),
    .rel_idx_i(rel_idx),
    .rank_o   (rank)
  );

  bcq_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (scan_clr),
    .vld_i   (vld_q),
    .idx_i   (bcq_pkg::IdxW'(idx_q)),
    .rank_i  (bcq_pkg::IdxW'(rank[idx_q])),
    .used_i  (used_q[idx_q]),
    .busy_i  (busy_q[idx_q]),
    .tag_i   (mem_rdata),
    .device_i(req_q.device),
    .sector_i(req_q.sector),
    .inode_i (req_q.inode),
    .sum_o   (sum)
  );

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    used_d   = used_q;
    busy_d   = busy_q;
    res_d    = res_q;
    done_d   = 1'b0;
    mem_we   = 1'b0;
    rel_en   = 1'b0;
    scan_clr = 1'b0;
    case (state_q)
      bcq_pkg::S_IDLE: begin
        if (start) begin
          scan_clr = 1'b1;
          cnt_d    = '0;
          state_d  = (req_i.operation == bcq_pkg::OP_RELEASE) ? bcq_pkg::S_REL
                                                              : bcq_pkg::S_SCAN;
        end
      end
      bcq_pkg::S_REL: begin
        rel_en = rel_ok;
        if (rel_ok) begin
          busy_d[rel_idx] = 1'b0;
        end
        res_d.status        = rel_ok ? bcq_pkg::ST_HIT : bcq_pkg::ST_NOT_BUSY;
        res_d.granted_entry = '0;
        done_d              = 1'b1;
        state_d             = bcq_pkg::S_IDLE;
      end
      bcq_pkg::S_SCAN: begin
        if (cnt_q == IW'(NUM_ENTRIES - 1)) begin
          state_d = bcq_pkg::S_DRAIN;
        end else begin
          cnt_d = cnt_q + IW'(1);
        end
      end
      bcq_pkg::S_DRAIN: begin
        // last read word is folded in at the end of this cycle
        state_d = bcq_pkg::S_DECIDE;
      end
      bcq_pkg::S_DECIDE: begin
        res_d.granted_entry = '0;
        if (sum.hit_found) begin
          if (sum.hit_busy) begin
            res_d.status = bcq_pkg::ST_WAIT;
          end else begin
            busy_d[hit_idx]     = 1'b1;
            res_d.status        = bcq_pkg::ST_HIT;
            res_d.granted_entry = sum.hit_idx;
          end
        end else if (vic_found) begin
          mem_we              = 1'b1;
          used_d[vic_idx]     = 1'b1;
          busy_d[vic_idx]     = 1'b1;
          res_d.status        = bcq_pkg::ST_MISS;
          res_d.granted_entry = 6'(vic_idx);
        end else begin
          res_d.status = limited ? bcq_pkg::ST_WAIT : bcq_pkg::ST_FULL;
        end
        done_d  = 1'b1;
        state_d = bcq_pkg::S_IDLE;
      end
      default: begin
        state_d = bcq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcq_pkg::S_IDLE;
      cnt_q   <= '0;
      vld_q   <= 1'b0;
      idx_q   <= '0;
      used_q  <= '0;
      busy_q  <= '0;
      quota_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      vld_q   <= (state_q == bcq_pkg::S_SCAN);
      idx_q   <= cnt_q;
      used_q  <= used_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        quota_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_miss_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == bcq_pkg::ST_MISS)
      |-> (busy_q[res_o.granted_entry[IW-1:0]] && used_q[res_o.granted_entry[IW-1:0]]))
    else $error("allocated entry not marked used and busy");

  a_hit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == bcq_pkg::ST_HIT && $past(state_q) == bcq_pkg::S_DECIDE)
      |-> busy_q[res_o.granted_entry[IW-1:0]])
    else $error("hit entry not marked busy");

endmodule

`default_nettype wire
